// File: src/pli_pkg.sv
`default_nettype none
package pli_pkg;
  localparam int MaxKnots = 64;
  localparam int IdxW = 6;
  localparam int CntW = 7;
  localparam int ValW = 32;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_RANGE = 2'd2;

  typedef logic signed [ValW-1:0] val_t;

  typedef struct packed {
    logic start;
    logic signed [ValW:0] num;
    logic signed [ValW:0] den;
  } div_req_t;

  function automatic val_t sat64(input logic signed [63:0] v);
    val_t r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[ValW-1:0];
    return r;
  endfunction

  function automatic logic signed [63:0] floor16(input logic signed [63:0] p);
    return p >>> 16;
  endfunction
endpackage
`default_nettype wire

// File: src/pli_div.sv
`default_nettype none
module pli_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire pli_pkg::div_req_t req,
  output logic busy,
  output logic done,
  output pli_pkg::val_t quo
);
  import pli_pkg::*;
  logic [48:0] num_mag;
  logic [32:0] den_mag;
  logic [33:0] rem;
  logic [48:0] q;
  logic [5:0] cnt;
  logic neg;
  logic [34:0] trial;
  logic signed [50:0] sq;

  assign trial = {rem, num_mag[48]} - {2'd0, den_mag};
  assign sq = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd49;
        rem <= '0;
        q <= '0;
        neg <= req.num[ValW] ^ req.den[ValW];
        num_mag <= {(req.num[ValW] ? 33'(-req.num) : 33'(req.num)), 16'd0};
        den_mag <= req.den[ValW] ? 33'(-req.den) : 33'(req.den);
      end else if (busy) begin
        num_mag <= {num_mag[47:0], 1'b0};
        if (!trial[34]) begin
          rem <= trial[33:0];
          q <= {q[47:0], 1'b1};
        end else begin
          rem <= {rem[32:0], num_mag[48]};
          q <= {q[47:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (sq > 51'sd2147483647) quo = 32'sh7fffffff;
    else if (sq < -51'sd2147483648) quo = 32'sh80000000;
    else quo = sq[31:0];
  end
endmodule
`default_nettype wire

// File: src/pli_ctrl.sv
`default_nettype none
module pli_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [pli_pkg::CntW-1:0] knot_count,
  input  wire logic in_go,
  input  wire logic [1:0] opcode,
  input  wire logic [pli_pkg::IdxW-1:0] knot_index,
  input  wire pli_pkg::val_t knot_x,
  input  wire pli_pkg::val_t knot_y,
  input  wire pli_pkg::val_t point_x,
  input  wire pli_pkg::val_t range_max_x,
  input  wire logic restart,
  output logic idle,
  output logic res_valid,
  input  wire logic res_stall,
  output pli_pkg::val_t res_x,
  output pli_pkg::val_t res_y,
  output logic res_last
);
  import pli_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_RESET = 4'd1, S_RD0 = 4'd2, S_RD1 = 4'd3,
    S_DIV = 4'd4, S_MUL = 4'd5, S_ICPT = 4'd6, S_ADV = 4'd7, S_EMUL = 4'd8,
    S_EOUT = 4'd9, S_WAIT = 4'd10, S_KNOT = 4'd11;

  logic [ValW-1:0] mem_x [MaxKnots];
  logic [ValW-1:0] mem_y [MaxKnots];
  logic [ValW-1:0] rd_x, rd_y;
  logic [IdxW-1:0] rd_addr;
  logic rd_en;

  logic [3:0] state;
  logic [1:0] op;
  logic phase;
  logic upper;
  logic emit;
  val_t px, mx, x0, y0, x1, y1, slope, icpt, high_x, eval_x;
  logic [CntW-1:0] seg, n;
  logic signed [63:0] prod;
  div_req_t dreq;
  logic dbusy, ddone;
  val_t dq;

  always_ff @(posedge clk) begin
    if (in_go && opcode == OP_LOAD) begin
      mem_x[knot_index] <= knot_x;
      mem_y[knot_index] <= knot_y;
    end
    if (rd_en) begin
      rd_x <= mem_x[rd_addr];
      rd_y <= mem_y[rd_addr];
    end
  end

  pli_div u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .done(ddone), .quo(dq));

  always_comb begin
    rd_en = 1'b0;
    rd_addr = seg[IdxW-1:0];
    case (state)
      S_RESET: begin rd_en = 1'b1; rd_addr = '0; end
      S_RD0: begin rd_en = 1'b1; rd_addr = seg[IdxW-1:0]; end
      S_ADV: begin rd_en = 1'b1; rd_addr = seg[IdxW-1:0]; end
      default: ;
    endcase
  end

  assign idle = (state == S_IDLE) && !res_valid;
  assign emit = (state == S_KNOT || state == S_EOUT) && (!res_valid || !res_stall);
  assign dreq = {(state == S_DIV) && !phase,
                 $signed({y1[ValW-1], y1}) - $signed({y0[ValW-1], y0}),
                 $signed({x1[ValW-1], x1}) - $signed({x0[ValW-1], x0})};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      seg <= 7'd1;
      slope <= '0;
      icpt <= '0;
      high_x <= '0;
      phase <= 1'b0;
    end else begin
      if (res_valid && !res_stall && !emit) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_go) begin
            op <= opcode;
            px <= point_x;
            mx <= range_max_x;
            upper <= 1'b0;
            n <= (knot_count > 7'(MaxKnots)) ? 7'(MaxKnots) : knot_count;
            if (opcode == OP_RANGE || (opcode == OP_POINT && restart)) state <= S_RESET;
            else if (opcode == OP_POINT) state <= S_ADV;
          end
        end
        S_RESET: begin
          seg <= 7'd1;
          phase <= 1'b0;
          state <= S_RD0;
        end
        S_RD0: begin
          if (!phase) begin
            x0 <= rd_x; y0 <= rd_y; phase <= 1'b1;
            if (n <= 7'd1) begin
              slope <= '0;
              icpt <= (n == 7'd1) ? rd_y : '0;
              high_x <= '0;
              phase <= 1'b0;
              state <= S_ADV;
            end
          end else begin
            x1 <= rd_x; y1 <= rd_y; phase <= 1'b0;
            state <= S_DIV;
          end
        end
        S_RD1: state <= S_DIV;
        S_DIV: begin
          if (!phase) phase <= 1'b1;
          else if (ddone) begin
            slope <= (x1 == x0) ? '0 : dq;
            phase <= 1'b0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= $signed(slope) * $signed(x1);
          state <= S_ICPT;
        end
        S_ICPT: begin
          icpt <= sat64(64'($signed(y1)) - floor16(prod));
          high_x <= x1;
          state <= S_ADV;
        end
        S_ADV: begin
          eval_x <= upper ? mx : px;
          if ((upper ? mx : px) > high_x &&
              {1'b0, seg} + 8'd1 < {1'b0, n}) begin
            if (upper) state <= S_KNOT;
            else begin
              x0 <= x1; y0 <= y1;
              seg <= seg + 7'd1;
              state <= S_WAIT;
            end
          end else state <= S_EMUL;
        end
        S_KNOT: begin
          if (emit) begin
            res_valid <= 1'b1;
            res_x <= x1; res_y <= y1; res_last <= 1'b0;
            x0 <= x1; y0 <= y1;
            seg <= seg + 7'd1;
            phase <= 1'b0;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          phase <= 1'b0;
          state <= S_RD0;
        end
        S_EMUL: begin
          prod <= $signed(slope) * $signed(eval_x);
          state <= S_EOUT;
        end
        S_EOUT: begin
          if (emit) begin
            res_valid <= 1'b1;
            res_x <= eval_x;
            res_y <= sat64(floor16(prod) + 64'($signed(icpt)));
            res_last <= !(op == OP_RANGE && !upper);
            phase <= 1'b0;
            if (op == OP_RANGE && !upper) begin
              upper <= 1'b1;
              state <= S_ADV;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: src/piecewise_linear_interpolator_top.sv
`default_nettype none
// channel | direction | handshake          | fields
// in      | in        | in_valid/in_stall  | opcode knot_index knot_x knot_y point_x ...
// out     | out       | out_valid/out_stall| out_x out_y last
// cfg     | in        | cfg_we             | cfg_data (knot_count)
// A load writes one knot; a segment load runs the 49-step divider.
// A point needs one segment load per knot crossed; a restart or a range adds one more.
// A range emits a word at each end and one per knot passed between them.
// Synchronous reset clears the cursor and knot_count; table is undefined.
// Input stalls while a word is being worked; output register holds under stall.
module piecewise_linear_interpolator_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [6:0] cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [1:0] opcode,
  input  wire logic [5:0] knot_index,
  input  wire logic signed [31:0] knot_x,
  input  wire logic signed [31:0] knot_y,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] range_max_x,
  input  wire logic restart,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic last
);
  import pli_pkg::*;
  logic [CntW-1:0] knot_count;
  logic idle, busy_n;

  always_ff @(posedge clk) begin
    if (rst) knot_count <= '0;
    else if (cfg_we) knot_count <= cfg_data;
  end

  pli_ctrl u_ctrl (
    .clk(clk), .rst(rst), .knot_count(knot_count),
    .in_go(in_valid && !in_stall), .opcode(opcode), .knot_index(knot_index),
    .knot_x(knot_x), .knot_y(knot_y), .point_x(point_x), .range_max_x(range_max_x),
    .restart(restart), .idle(busy_n), .res_valid(out_valid), .res_stall(out_stall),
    .res_x(out_x), .res_y(out_y), .res_last(last)
  );

  assign idle = busy_n;
  assign in_stall = !idle;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("word dropped");
  a_nostart: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> !(in_valid && !in_stall)) else $error("accept while busy");
  a_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("valid after reset");
endmodule
`default_nettype wire
